// File: rtl/core/tccw_pkg.sv
// Shared types and constants for the text console cell writer.
package tccw_pkg;

    // Payload field widths, fixed by the item format
    localparam int CharW = 8;
    localparam int AttrW = 8;
    localparam int ColW  = 7;
    localparam int RowW  = 5;

    // Function codes
    localparam logic FuncPut  = 1'b0;
    localparam logic FuncRead = 1'b1;

    // Character and colour codes
    localparam logic [CharW-1:0] NewlineCode = 8'h0A;
    localparam logic [CharW-1:0] SpaceCode   = 8'h20;
    localparam logic [AttrW-1:0] LightGrey   = 8'h07;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SCROLL,
        S_SCROLL_END,
        S_RESULT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic clr_write;    // write reset value at sweep pointer
        logic ptr_clear;    // sweep pointer to zero
        logic ptr_inc;      // advance sweep pointer
        logic ld_item;      // capture an accepted input item
        logic put_write;    // write character (or space) at the cursor
        logic adv_col;      // cursor one column right
        logic next_row;     // cursor to column 0, down one row unless on the last row
        logic set_scrolled; // note that this item scrolled
        logic read_cell;    // issue store read for a read item
        logic scroll_read;  // read source cell of the row shift
        logic scroll_write; // write destination cell of the row shift
        logic ld_out;       // load the result register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_last;     // sweep pointer at last cell
        logic scr_last;     // sweep pointer at last shift source
        logic ptr_zero;     // sweep pointer at zero
        logic col_last;     // cursor on last column
        logic row_last;     // cursor on last row
        logic is_read;      // captured item is a read
        logic is_newline;   // captured item is a newline
    } t_status;

endpackage

// File: rtl/core/tccw_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/tccw_ctrl.sv
// Controller state machine: clearing pass, item sequencing, row shift, result hand-off.
module tccw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  tccw_pkg::t_status i_status,
    output tccw_pkg::t_cmd    o_cmd
);

    import tccw_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   in_ready;
    logic   accept;

    // Result register can take a new result this cycle
    assign out_free = !r_out_valid || !i_stall;
    assign in_ready = (r_state == S_IDLE) || ((r_state == S_RESULT) && out_free);
    assign accept   = in_ready && i_valid;

    assign o_stall = !in_ready;
    assign o_valid = r_out_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_status.is_read) begin
                    n_state = S_RESULT;
                end else if (i_status.col_last) begin
                    n_state = i_status.row_last ? S_SCROLL : S_RESULT;
                end else if (!i_status.is_newline) begin
                    n_state = S_RESULT;
                end
            end
            S_SCROLL: begin
                if (i_status.scr_last) n_state = S_SCROLL_END;
            end
            S_SCROLL_END: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) n_state = accept ? S_EXEC : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                o_cmd.ptr_inc   = 1'b1;
            end
            S_IDLE: begin
                o_cmd.ld_item = accept;
            end
            S_EXEC: begin
                if (i_status.is_read) begin
                    o_cmd.read_cell = 1'b1;
                end else begin
                    o_cmd.put_write = 1'b1;
                    if (i_status.col_last) begin
                        o_cmd.next_row = 1'b1;
                        if (i_status.row_last) begin
                            o_cmd.set_scrolled = 1'b1;
                            o_cmd.ptr_clear    = 1'b1;
                        end
                    end else begin
                        o_cmd.adv_col = 1'b1;
                    end
                end
            end
            S_SCROLL: begin
                o_cmd.scroll_read  = 1'b1;
                o_cmd.ptr_inc      = 1'b1;
                o_cmd.scroll_write = !i_status.ptr_zero;
            end
            S_SCROLL_END: begin
                o_cmd.scroll_write = 1'b1;
            end
            S_RESULT: begin
                o_cmd.ld_out  = out_free;
                o_cmd.ld_item = accept;
            end
            default: o_cmd = '0;
        endcase
    end

    // Result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.ld_out) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/core/tccw_dpath.sv
// Datapath: cell store, cursor, sweep pointer, captured item and result registers.
module tccw_dpath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tccw_pkg::t_cmd                 i_cmd,
    output tccw_pkg::t_status              o_status,
    input  logic                           i_func,
    input  logic [tccw_pkg::CharW-1:0]     i_char_code,
    input  logic [tccw_pkg::AttrW-1:0]     i_attr,
    input  logic [tccw_pkg::ColW-1:0]      i_read_col,
    input  logic [tccw_pkg::RowW-1:0]      i_read_row,
    output logic [tccw_pkg::CharW-1:0]     o_cell_char,
    output logic [tccw_pkg::AttrW-1:0]     o_cell_attr,
    output logic [tccw_pkg::ColW-1:0]      o_cursor_col,
    output logic [tccw_pkg::RowW-1:0]      o_cursor_row,
    output logic                           o_scrolled
);

    import tccw_pkg::*;

    localparam int Cells  = COLUMNS * ROWS;
    localparam int AddrW  = $clog2(Cells);
    localparam int XW     = $clog2(COLUMNS);
    localparam int YW     = $clog2(ROWS);
    localparam int CellW  = CharW + AttrW;

    localparam logic [AddrW-1:0] ColsA    = AddrW'(COLUMNS);
    localparam logic [AddrW-1:0] LastCell = AddrW'(Cells - 1);
    localparam logic [AddrW-1:0] LastSrc  = AddrW'(Cells - COLUMNS - 1);
    localparam logic [XW-1:0]    LastCol  = XW'(COLUMNS - 1);
    localparam logic [YW-1:0]    LastRow  = YW'(ROWS - 1);

    // Cursor and sweep pointer
    logic [XW-1:0]    r_cur_x;
    logic [YW-1:0]    r_cur_y;
    logic [AddrW-1:0] r_base;
    logic [AddrW-1:0] r_ptr;
    logic             r_scrolled;

    // Captured item
    logic             r_func;
    logic [CharW-1:0] r_char;
    logic [AttrW-1:0] r_attr;
    logic [ColW-1:0]  r_rd_col;
    logic [RowW-1:0]  r_rd_row;
    logic             r_in_range;

    // Result register
    logic [CharW-1:0] r_cell_char;
    logic [AttrW-1:0] r_cell_attr;
    logic [ColW-1:0]  r_cursor_col;
    logic [RowW-1:0]  r_cursor_row;
    logic             r_out_scrolled;

    logic             ram_we;
    logic [AddrW-1:0] ram_waddr;
    logic [CellW-1:0] ram_wdata;
    logic             ram_re;
    logic [AddrW-1:0] ram_raddr;
    logic [CellW-1:0] ram_rdata;
    logic [AddrW-1:0] cur_addr;
    logic [AddrW-1:0] rd_addr;
    logic [CharW-1:0] put_char;

    assign cur_addr = r_base + AddrW'(r_cur_x);
    assign rd_addr  = AddrW'(r_rd_row * ColsA) + AddrW'(r_rd_col);
    assign put_char = (r_char == NewlineCode) ? SpaceCode : r_char;

    // Store write port
    always_comb begin
        ram_we    = i_cmd.clr_write || i_cmd.put_write || i_cmd.scroll_write;
        ram_waddr = r_ptr;
        ram_wdata = {LightGrey, SpaceCode};
        priority if (i_cmd.put_write) begin
            ram_waddr = cur_addr;
            ram_wdata = {r_attr, put_char};
        end else if (i_cmd.scroll_write) begin
            ram_waddr = r_ptr - AddrW'(1);
            ram_wdata = ram_rdata;
        end else begin
            ram_waddr = r_ptr;
            ram_wdata = {LightGrey, SpaceCode};
        end
    end

    // Store read port: shift source sits one row below the pointer
    assign ram_re    = i_cmd.read_cell || i_cmd.scroll_read;
    assign ram_raddr = i_cmd.scroll_read ? (r_ptr + ColsA) : rd_addr;

    tccw_ram #(
        .WIDTH (CellW),
        .DEPTH (Cells)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Cursor, pointer and scroll flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_base     <= '0;
            r_ptr      <= '0;
            r_scrolled <= 1'b0;
        end else begin
            if (i_cmd.adv_col) begin
                r_cur_x <= r_cur_x + XW'(1);
            end else if (i_cmd.next_row) begin
                r_cur_x <= '0;
                if (r_cur_y != LastRow) begin
                    r_cur_y <= r_cur_y + YW'(1);
                    r_base  <= r_base + ColsA;
                end
            end
            if (i_cmd.ptr_clear) begin
                r_ptr <= '0;
            end else if (i_cmd.ptr_inc) begin
                r_ptr <= r_ptr + AddrW'(1);
            end
            if (i_cmd.ld_item) begin
                r_scrolled <= 1'b0;
            end else if (i_cmd.set_scrolled) begin
                r_scrolled <= 1'b1;
            end
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_func     <= i_func;
            r_char     <= i_char_code;
            r_attr     <= i_attr;
            r_rd_col   <= i_read_col;
            r_rd_row   <= i_read_row;
            r_in_range <= (32'(i_read_col) < COLUMNS) && (32'(i_read_row) < ROWS);
        end
    end

    // Result capture; read data is held by the store since the read was issued
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            if ((r_func == FuncRead) && r_in_range) begin
                r_cell_char <= ram_rdata[CharW-1:0];
                r_cell_attr <= ram_rdata[CellW-1:CharW];
            end else begin
                r_cell_char <= '0;
                r_cell_attr <= '0;
            end
            r_cursor_col   <= ColW'(r_cur_x);
            r_cursor_row   <= RowW'(r_cur_y);
            r_out_scrolled <= r_scrolled;
        end
    end

    assign o_cell_char  = r_cell_char;
    assign o_cell_attr  = r_cell_attr;
    assign o_cursor_col = r_cursor_col;
    assign o_cursor_row = r_cursor_row;
    assign o_scrolled   = r_out_scrolled;

    // Status
    assign o_status.clr_last   = (r_ptr == LastCell);
    assign o_status.scr_last   = (r_ptr == LastSrc);
    assign o_status.ptr_zero   = (r_ptr == '0);
    assign o_status.col_last   = (r_cur_x == LastCol);
    assign o_status.row_last   = (r_cur_y == LastRow);
    assign o_status.is_read    = (r_func == FuncRead);
    assign o_status.is_newline = (r_char == NewlineCode);

endmodule

// File: rtl/core/text_console_cell_writer_core.sv
// Top level of the text console cell writer.
// Character-cell console of COLUMNS x ROWS cells with a cursor. After reset a clearing
// pass writes space in light grey to every cell, one cell per cycle, and no item is
// taken until it ends. A newline writes one cell per cycle, from the cursor to the end
// of its row. Moving past the last row shifts the screen up through the single write
// port of the cell store, one cell per cycle. One result per item is held in an output
// register, and the next item is taken while it waits.
module text_console_cell_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_func,
    input  logic [tccw_pkg::CharW-1:0] i_char_code,
    input  logic [tccw_pkg::AttrW-1:0] i_attr,
    input  logic [tccw_pkg::ColW-1:0]  i_read_col,
    input  logic [tccw_pkg::RowW-1:0]  i_read_row,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [tccw_pkg::CharW-1:0] o_cell_char,
    output logic [tccw_pkg::AttrW-1:0] o_cell_attr,
    output logic [tccw_pkg::ColW-1:0]  o_cursor_col,
    output logic [tccw_pkg::RowW-1:0]  o_cursor_row,
    output logic                       o_scrolled
);

    import tccw_pkg::*;

    t_cmd    cmd;
    t_status status;

    tccw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    tccw_dpath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_func       (i_func),
        .i_char_code  (i_char_code),
        .i_attr       (i_attr),
        .i_read_col   (i_read_col),
        .i_read_row   (i_read_row),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_scrolled   (o_scrolled)
    );

endmodule

// File: verif/console_cell_checker.sv
// Checker for the text console: mirrors the screen and cursor, predicts each result, compares.
module console_cell_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_func,
    input  logic [tccw_pkg::CharW-1:0] i_char_code,
    input  logic [tccw_pkg::AttrW-1:0] i_attr,
    input  logic [tccw_pkg::ColW-1:0]  i_read_col,
    input  logic [tccw_pkg::RowW-1:0]  i_read_row,
    // result channel
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [tccw_pkg::CharW-1:0] i_cell_char,
    input  logic [tccw_pkg::AttrW-1:0] i_cell_attr,
    input  logic [tccw_pkg::ColW-1:0]  i_cursor_col,
    input  logic [tccw_pkg::RowW-1:0]  i_cursor_row,
    input  logic                       i_scrolled,
    // to the testbench top
    output int                         o_mismatches,
    output int                         o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import tccw_pkg::*;

    localparam int Cells = COLUMNS * ROWS;

    typedef struct packed {
        logic [CharW-1:0] cell_char;
        logic [AttrW-1:0] cell_attr;
        logic [ColW-1:0]  cursor_col;
        logic [RowW-1:0]  cursor_row;
        logic             scrolled;
    } t_console_result;

    // Mirror of the screen and cursor
    logic [CharW-1:0] screen_chars [0:Cells-1];
    logic [AttrW-1:0] screen_attrs [0:Cells-1];
    int               cur_col;
    int               cur_row;

    t_console_result  awaited_results [$];
    int               mismatch_total;

    // Apply one item to the mirror and return the result it should produce
    function automatic t_console_result apply_console_item(
        input logic             func,
        input logic [CharW-1:0] code,
        input logic [AttrW-1:0] colour,
        input logic [ColW-1:0]  rcol,
        input logic [RowW-1:0]  rrow
    );
        t_console_result res;
        logic            row_done;
        int              idx;
        res      = '0;
        row_done = 1'b0;
        if (func == FuncRead) begin
            // reads off the screen give zero
            if (int'(rcol) < COLUMNS && int'(rrow) < ROWS) begin
                res.cell_char = screen_chars[int'(rrow) * COLUMNS + int'(rcol)];
                res.cell_attr = screen_attrs[int'(rrow) * COLUMNS + int'(rcol)];
            end
        end else if (code == NewlineCode) begin
            // blank from the cursor to the end of the row, cursor cell included
            for (idx = cur_col; idx < COLUMNS; idx++) begin
                screen_chars[cur_row * COLUMNS + idx] = SpaceCode;
                screen_attrs[cur_row * COLUMNS + idx] = colour;
            end
            row_done = 1'b1;
        end else begin
            screen_chars[cur_row * COLUMNS + cur_col] = code;
            screen_attrs[cur_row * COLUMNS + cur_col] = colour;
            cur_col++;
            if (cur_col >= COLUMNS) begin
                row_done = 1'b1;
            end
        end
        // next row; past the bottom every row moves up and the bottom row stays as it was
        if (row_done) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= ROWS) begin
                for (idx = 0; idx < Cells - COLUMNS; idx++) begin
                    screen_chars[idx] = screen_chars[idx + COLUMNS];
                    screen_attrs[idx] = screen_attrs[idx + COLUMNS];
                end
                cur_row      = ROWS - 1;
                res.scrolled = 1'b1;
            end
        end
        res.cursor_col = ColW'(cur_col);
        res.cursor_row = RowW'(cur_row);
        return res;
    endfunction

    function automatic void compare_field(
        input string       field,
        input int unsigned want,
        input int unsigned got
    );
        if (want != got) begin
            mismatch_total++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    // Track both channels at every edge
    always @(posedge i_clk) begin
        t_console_result got;
        t_console_result want;
        int              idx;
        if (!i_rst_n) begin
            for (idx = 0; idx < Cells; idx++) begin
                screen_chars[idx] = SpaceCode;
                screen_attrs[idx] = LightGrey;
            end
            cur_col = 0;
            cur_row = 0;
            awaited_results.delete();
            mismatch_total = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                awaited_results.push_back(apply_console_item(i_func, i_char_code, i_attr,
                                                             i_read_col, i_read_row));
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_cell_char, i_cell_attr, i_cursor_col, i_cursor_row, i_scrolled};
                if (awaited_results.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: result transfer with none expected, expected none, %s",
                             $time, "got");
                    $display("    char %0d attr %0d col %0d row %0d scrolled %0d",
                             got.cell_char, got.cell_attr, got.cursor_col,
                             got.cursor_row, got.scrolled);
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("cell_char", want.cell_char, got.cell_char);
                    compare_field("cell_attr", want.cell_attr, got.cell_attr);
                    compare_field("cursor_col", want.cursor_col, got.cursor_col);
                    compare_field("cursor_row", want.cursor_row, got.cursor_row);
                    compare_field("scrolled", want.scrolled, got.scrolled);
                end
            end
        end
        o_pending    <= awaited_results.size();
        o_mismatches <= mismatch_total;
    end

endmodule

// File: verif/tb_top.sv
// Testbench top for the text console cell writer: clock, reset, stimulus and verdict.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import tccw_pkg::*;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int ClkPeriod  = 10;
    localparam int ItemTarget = 650;
    // clearing pass and a scroll each hold off transfers while they sweep the cell store
    localparam int IdleLimit  = 20000;
    localparam int DrainWait  = 100;

    typedef enum int {
        MixedTraffic,
        LongLine,
        NewlineBurst,
        ReadSweep
    } t_traffic;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    logic             i_func      = FuncPut;
    logic [CharW-1:0] i_char_code = '0;
    logic [AttrW-1:0] i_attr      = '0;
    logic [ColW-1:0]  i_read_col  = '0;
    logic [RowW-1:0]  i_read_row  = '0;
    logic             i_stall     = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic [CharW-1:0] o_cell_char;
    logic [AttrW-1:0] o_cell_attr;
    logic [ColW-1:0]  o_cursor_col;
    logic [RowW-1:0]  o_cursor_row;
    logic             o_scrolled;

    int               mismatches;
    int               pending;
    int               sent = 0;
    logic             calm = 1'b0;

    always #(ClkPeriod / 2) i_clk = ~i_clk;

    text_console_cell_writer_core #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_char_code (i_char_code),
        .i_attr      (i_attr),
        .i_read_col  (i_read_col),
        .i_read_row  (i_read_row),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_cell_char (o_cell_char),
        .o_cell_attr (o_cell_attr),
        .o_cursor_col(o_cursor_col),
        .o_cursor_row(o_cursor_row),
        .o_scrolled  (o_scrolled)
    );

    console_cell_checker #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_func      (i_func),
        .i_char_code (i_char_code),
        .i_attr      (i_attr),
        .i_read_col  (i_read_col),
        .i_read_row  (i_read_row),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_cell_char (o_cell_char),
        .i_cell_attr (o_cell_attr),
        .i_cursor_col(o_cursor_col),
        .i_cursor_row(o_cursor_row),
        .i_scrolled  (o_scrolled),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    // Result side back-pressure, off during the calm stretch
    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < 9);
    end

    // One input transfer, with an occasional gap in front of it
    task automatic send_item(
        input logic             func,
        input logic [CharW-1:0] code,
        input logic [AttrW-1:0] colour,
        input logic [ColW-1:0]  rcol,
        input logic [RowW-1:0]  rrow
    );
        if (!calm && $urandom_range(0, 99) < 9) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_func      <= func;
        i_char_code <= code;
        i_attr      <= colour;
        i_read_col  <= rcol;
        i_read_row  <= rrow;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
    endtask

    // Random item shaped by the current traffic kind
    task automatic send_random(input t_traffic kind);
        logic             func;
        logic [CharW-1:0] code;
        logic [AttrW-1:0] colour;
        logic [ColW-1:0]  rcol;
        logic [RowW-1:0]  rrow;
        func   = FuncPut;
        code   = CharW'($urandom_range(0, 255));
        colour = AttrW'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 85) begin
            rcol = ColW'($urandom_range(0, COLUMNS - 1));
            rrow = RowW'($urandom_range(0, ROWS - 1));
        end else begin
            rcol = ColW'($urandom_range(0, 127));
            rrow = RowW'($urandom_range(0, 31));
        end
        case (kind)
            LongLine: begin
                // no newline, so the line wraps at the last column
                if (code == NewlineCode) code = SpaceCode;
            end
            NewlineBurst: begin
                if ($urandom_range(0, 3) != 0) code = NewlineCode;
            end
            ReadSweep: begin
                func = FuncRead;
            end
            default: begin
                func = ($urandom_range(0, 99) < 40) ? FuncRead : FuncPut;
                if (func == FuncPut && $urandom_range(0, 9) == 0) code = NewlineCode;
            end
        endcase
        send_item(func, code, colour, rcol, rrow);
    endtask

    // Stall-free watchdog: ends the run if no transfer happens for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IdleLimit) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle = 0;
            else idle++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        t_traffic kind;
        int       len;
        int       k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset contents at both corners, then reads off the screen
        send_item(FuncRead, 8'h00, 8'h00, 7'd0, 5'd0);
        send_item(FuncRead, 8'hFF, 8'hFF, ColW'(COLUMNS - 1), RowW'(ROWS - 1));
        send_item(FuncRead, 8'h00, 8'h00, ColW'(COLUMNS), 5'd0);
        send_item(FuncRead, NewlineCode, 8'hFF, 7'd127, 5'd31);
        send_item(FuncRead, 8'h41, 8'h00, 7'd0, RowW'(ROWS));
        // puts ignore the read position; character zero is an ordinary character
        send_item(FuncPut, 8'h41, 8'h1F, 7'd127, 5'd31);
        send_item(FuncPut, 8'h00, 8'h00, 7'd0, 5'd0);
        send_item(FuncPut, 8'hFF, 8'hFF, 7'd85, 5'd26);
        // newline mid-row, then at column 0
        send_item(FuncPut, NewlineCode, 8'h4E, 7'd0, 5'd0);
        send_item(FuncPut, NewlineCode, 8'hA5, 7'd0, 5'd0);
        send_item(FuncRead, 8'h00, 8'h00, 7'd0, 5'd0);
        send_item(FuncRead, 8'h00, 8'h00, 7'd1, 5'd0);
        send_item(FuncRead, 8'h00, 8'h00, 7'd2, 5'd0);
        send_item(FuncRead, 8'h00, 8'h00, 7'd3, 5'd0);
        send_item(FuncRead, 8'h00, 8'h00, ColW'(COLUMNS - 1), 5'd0);
        send_item(FuncRead, 8'h00, 8'h00, 7'd0, 5'd1);
        send_item(FuncRead, 8'h00, 8'h00, ColW'(COLUMNS - 1), 5'd1);
        send_item(FuncRead, 8'h00, 8'h00, 7'd0, 5'd2);

        // random traffic in segments of one kind each
        sent = 0;
        while (sent < ItemTarget) begin
            calm = (sent >= 250 && sent < 380);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin kind = MixedTraffic; len = $urandom_range(20, 40); end
                4, 5:       begin kind = LongLine;     len = $urandom_range(60, 120); end
                6, 7:       begin kind = NewlineBurst; len = $urandom_range(3, 12); end
                default:    begin kind = ReadSweep;    len = $urandom_range(10, 25); end
            endcase
            for (k = 0; k < len; k++) begin
                send_random(kind);
            end
        end
        calm    = 1'b0;
        i_valid <= 1'b0;

        // drain once the checker has counted the last transfer, then watch for stray results
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
